// ===== src/assert_macros.svh =====
// Assertion macros shared by the token scanner RTL.
// Define NO_ASSERTIONS to compile every use away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked check, masked while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds across reset.
`define ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NORST(lbl, clk, prop, msg)

`endif

`endif

// ===== src/tsd_pkg.sv =====
// Types, codes and keyword tables of the token scanner.
// No dependencies; used by every RTL file of the block.
`default_nettype none

package tsd_pkg;

  localparam int LENGTH_BITS_DEF = 8;
  localparam int FIFO_DEPTH      = 4;
  localparam int NUM_KW          = 5;

  localparam logic [NUM_KW-1:0] CAND_ALL = '1;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_USCORE = "_";
  localparam logic [7:0] CH_SLASH  = "/";
  localparam logic [7:0] CH_EQ     = "=";
  localparam logic [7:0] CH_AMP    = "&";
  localparam logic [7:0] CH_BAR    = "|";

  // Keyword text, five characters each, padded with blanks past the length.
  localparam logic [39:0] KW_TXT [NUM_KW] = '{"int  ", "if   ", "else ", "while", "print"};
  localparam logic [2:0]  KW_LEN [NUM_KW] = '{3'd3, 3'd2, 3'd4, 3'd5, 3'd5};

  typedef enum logic [4:0] {
    ST_IDLE, ST_NUM, ST_IDENT, ST_MINUS, ST_DIV, ST_ASSIGN, ST_NOT, ST_LESS,
    ST_GREAT, ST_AND1, ST_OR1, ST_COMMENT,
    ST_DONE_ADD, ST_DONE_MUL, ST_DONE_MOD, ST_DONE_EQ, ST_DONE_NE, ST_DONE_LE,
    ST_DONE_GE, ST_DONE_AND, ST_DONE_OR, ST_DONE_SEMI, ST_DONE_COMMA,
    ST_DONE_LPAREN, ST_DONE_RPAREN, ST_DONE_LBRACE, ST_DONE_RBRACE
  } scan_state_t;

  typedef enum logic [4:0] {
    TK_END, TK_NUMBER, TK_IDENT, TK_KW_INT, TK_KW_IF, TK_KW_ELSE, TK_KW_WHILE,
    TK_KW_PRINT, TK_PLUS, TK_MINUS, TK_STAR, TK_SLASH, TK_PERCENT, TK_ASSIGN,
    TK_EQ, TK_NE, TK_NOT, TK_LT, TK_LE, TK_GT, TK_GE, TK_AND, TK_OR, TK_SEMI,
    TK_COMMA, TK_LPAREN, TK_RPAREN, TK_LBRACE, TK_RBRACE, TK_NOTOK, TK_INVALID
  } tok_kind_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [4:0] token_kind;
    logic [7:0] lexeme_length;
    logic       last;
  } out_item_t;

  // Up to two results per item, in order; vld1 implies vld0.
  typedef struct packed {
    logic      vld0;
    out_item_t item0;
    logic      vld1;
    out_item_t item1;
  } res_wr_t;

  function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] p);
    logic [39:0] t;
    t = KW_TXT[k] << {p, 3'b000};
    return t[39:32];
  endfunction

  function automatic tok_kind_t kw_kind(input logic [2:0] k);
    tok_kind_t r;
    case (k)
      3'd0:    r = TK_KW_INT;
      3'd1:    r = TK_KW_IF;
      3'd2:    r = TK_KW_ELSE;
      3'd3:    r = TK_KW_WHILE;
      3'd4:    r = TK_KW_PRINT;
      default: r = TK_IDENT;
    endcase
    return r;
  endfunction

  function automatic out_item_t mk_item(input tok_kind_t kind, input logic [7:0] len,
                                        input logic last);
    out_item_t r;
    r.token_kind    = kind;
    r.lexeme_length = len;
    r.last          = last;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/tsd_core.sv =====
// Scanner state machine: state, length counter and keyword candidates,
// plus the result decode for one item. Depends on tsd_pkg.
`default_nettype none

module tsd_core
  import tsd_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     fire,
  input  in_item_t item,
  output res_wr_t  wr
);

  scan_state_t             state_r, state_nxt;
  logic [LENGTH_BITS-1:0]  len_r, len_nxt, len_inc;
  logic [NUM_KW-1:0]       cand_r, cand_nxt;

  logic [7:0] c;
  logic       eoi;
  logic       ch_digit, ch_lower, ch_upper, is_idch;

  logic        starts, start_up, is_inv;
  scan_state_t start_st;

  logic                   cont;
  scan_state_t            cont_st;
  logic [LENGTH_BITS-1:0] cont_len;
  logic [NUM_KW-1:0]      cont_cand;

  logic [7:0] len8;
  tok_kind_t  pend_kind;
  logic       pend_present;
  logic       absorbed;

  assign c   = item.char_code;
  assign eoi = item.end_of_input;

  assign ch_digit = (c >= "0") && (c <= "9");
  assign ch_lower = (c >= "a") && (c <= "z");
  assign ch_upper = (c >= "A") && (c <= "Z");
  assign is_idch  = ch_digit || ch_lower || ch_upper || (c == CH_USCORE);

  assign len_inc = (len_r == '1) ? len_r : LENGTH_BITS'(len_r + 1'b1);

  // Drop every keyword that does not have ch at position p.
  function automatic logic [NUM_KW-1:0] narrow(input logic [NUM_KW-1:0] cand,
                                               input logic [LENGTH_BITS-1:0] p,
                                               input logic [7:0] ch);
    logic [NUM_KW-1:0] r;
    r = cand;
    for (int k = 0; k < NUM_KW; k++) begin
      if (!((p < LENGTH_BITS'(KW_LEN[k])) && (kw_char(3'(k), p[2:0]) == ch)))
        r[k] = 1'b0;
    end
    return r;
  endfunction

  if (LENGTH_BITS > 8) begin : g_sat
    assign len8 = (len_r > LENGTH_BITS'(255)) ? 8'hFF : len_r[7:0];
  end else begin : g_ext
    assign len8 = 8'(len_r);
  end

  // Kind of the token held in the current state.
  always_comb begin
    pend_kind = TK_NOTOK;
    case (state_r)
      ST_NUM: pend_kind = TK_NUMBER;
      ST_IDENT: begin
        pend_kind = TK_IDENT;
        // descending so the first matching keyword wins
        for (int k = NUM_KW - 1; k >= 0; k--) begin
          if (cand_r[k] && (len_r == LENGTH_BITS'(KW_LEN[k])))
            pend_kind = kw_kind(3'(k));
        end
      end
      ST_MINUS:       pend_kind = TK_MINUS;
      ST_DIV:         pend_kind = TK_SLASH;
      ST_ASSIGN:      pend_kind = TK_ASSIGN;
      ST_NOT:         pend_kind = TK_NOT;
      ST_LESS:        pend_kind = TK_LT;
      ST_GREAT:       pend_kind = TK_GT;
      ST_DONE_ADD:    pend_kind = TK_PLUS;
      ST_DONE_MUL:    pend_kind = TK_STAR;
      ST_DONE_MOD:    pend_kind = TK_PERCENT;
      ST_DONE_EQ:     pend_kind = TK_EQ;
      ST_DONE_NE:     pend_kind = TK_NE;
      ST_DONE_LE:     pend_kind = TK_LE;
      ST_DONE_GE:     pend_kind = TK_GE;
      ST_DONE_AND:    pend_kind = TK_AND;
      ST_DONE_OR:     pend_kind = TK_OR;
      ST_DONE_SEMI:   pend_kind = TK_SEMI;
      ST_DONE_COMMA:  pend_kind = TK_COMMA;
      ST_DONE_LPAREN: pend_kind = TK_LPAREN;
      ST_DONE_RPAREN: pend_kind = TK_RPAREN;
      ST_DONE_LBRACE: pend_kind = TK_LBRACE;
      ST_DONE_RBRACE: pend_kind = TK_RBRACE;
      default:        pend_kind = TK_NOTOK;
    endcase
  end

  // Decode of a character that starts a new token, from idle or once the token in progress ends.
  always_comb begin
    starts   = 1'b1;
    start_up = 1'b0;
    start_st = ST_IDLE;
    is_inv   = 1'b0;
    if (ch_digit) begin
      start_st = ST_NUM;
    end else if (ch_lower) begin
      start_st = ST_IDENT;
    end else if (ch_upper || (c == CH_USCORE)) begin
      start_st = ST_IDENT;
      start_up = 1'b1;
    end else begin
      case (c)
        "-":     start_st = ST_MINUS;
        "/":     start_st = ST_DIV;
        "+":     start_st = ST_DONE_ADD;
        "*":     start_st = ST_DONE_MUL;
        "%":     start_st = ST_DONE_MOD;
        "=":     start_st = ST_ASSIGN;
        "!":     start_st = ST_NOT;
        "<":     start_st = ST_LESS;
        ">":     start_st = ST_GREAT;
        "&":     start_st = ST_AND1;
        "|":     start_st = ST_OR1;
        ";":     start_st = ST_DONE_SEMI;
        ",":     start_st = ST_DONE_COMMA;
        "(":     start_st = ST_DONE_LPAREN;
        ")":     start_st = ST_DONE_RPAREN;
        "{":     start_st = ST_DONE_LBRACE;
        "}":     start_st = ST_DONE_RBRACE;
        CH_SPACE, CH_TAB, CH_NL: starts = 1'b0;
        default: begin
          starts = 1'b0;
          is_inv = 1'b1;
        end
      endcase
    end
  end

  // Does the character extend the token in progress?
  always_comb begin
    cont      = 1'b0;
    cont_st   = state_r;
    cont_len  = len_inc;
    cont_cand = cand_r;
    case (state_r)
      ST_NUM: cont = ch_digit;
      ST_IDENT: begin
        cont      = is_idch;
        cont_cand = narrow(cand_r, len_r, c);
      end
      ST_MINUS: begin
        cont    = ch_digit;
        cont_st = ST_NUM;
      end
      ST_DIV: begin
        cont     = (c == CH_SLASH);
        cont_st  = ST_COMMENT;
        cont_len = '0;
      end
      ST_ASSIGN: begin
        cont    = (c == CH_EQ);
        cont_st = ST_DONE_EQ;
      end
      ST_NOT: begin
        cont    = (c == CH_EQ);
        cont_st = ST_DONE_NE;
      end
      ST_LESS: begin
        cont    = (c == CH_EQ);
        cont_st = ST_DONE_LE;
      end
      ST_GREAT: begin
        cont    = (c == CH_EQ);
        cont_st = ST_DONE_GE;
      end
      ST_AND1: begin
        cont    = (c == CH_AMP);
        cont_st = ST_DONE_AND;
      end
      ST_OR1: begin
        cont    = (c == CH_BAR);
        cont_st = ST_DONE_OR;
      end
      ST_COMMENT: begin
        // swallow everything; newline ends the comment
        cont      = 1'b1;
        cont_len  = '0;
        cont_cand = CAND_ALL;
        if (c == CH_NL)
          cont_st = ST_IDLE;
      end
      default: cont = 1'b0;
    endcase
  end

  assign absorbed     = (state_r != ST_IDLE) && cont;
  assign pend_present = (state_r != ST_IDLE) && (state_r != ST_COMMENT);

  // Next state
  always_comb begin
    state_nxt = ST_IDLE;
    len_nxt   = '0;
    cand_nxt  = CAND_ALL;
    if (eoi) begin
      state_nxt = ST_IDLE;
    end else if (absorbed) begin
      state_nxt = cont_st;
      len_nxt   = cont_len;
      cand_nxt  = cont_cand;
    end else if (starts) begin
      state_nxt = start_st;
      len_nxt   = LENGTH_BITS'(1);
      if (start_st == ST_IDENT)
        cand_nxt = start_up ? '0 : narrow(CAND_ALL, '0, c);
    end
  end

  // Results of this item
  always_comb begin
    wr = '0;
    if (fire) begin
      if (eoi) begin
        wr.vld0 = 1'b1;
        if (pend_present) begin
          wr.item0 = mk_item(pend_kind, len8, 1'b0);
          wr.vld1  = 1'b1;
          wr.item1 = mk_item(TK_END, 8'd0, 1'b1);
        end else begin
          wr.item0 = mk_item(TK_END, 8'd0, 1'b1);
        end
      end else if (!absorbed) begin
        if (state_r != ST_IDLE) begin
          wr.vld0  = 1'b1;
          wr.item0 = mk_item(pend_kind, len8, !is_inv);
          if (is_inv) begin
            wr.vld1  = 1'b1;
            wr.item1 = mk_item(TK_INVALID, 8'd1, 1'b1);
          end
        end else if (is_inv) begin
          wr.vld0  = 1'b1;
          wr.item0 = mk_item(TK_INVALID, 8'd1, 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      len_r   <= '0;
      cand_r  <= CAND_ALL;
    end else if (fire) begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      cand_r  <= cand_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/tsd_res_fifo.sv =====
// Result queue: takes up to two results a cycle, hands out one.
// Depends on tsd_pkg.
`default_nettype none

module tsd_res_fifo
  import tsd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  res_wr_t   wr,
  output logic      room,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  out_item_t        mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, wr_ptr_p1;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       nwr;
  logic             pop;

  assign nwr       = {1'b0, wr.vld0} + {1'b0, wr.vld1};
  assign pop       = out_valid && out_ready;
  assign wr_ptr_p1 = PTR_W'(wr_ptr_r + 1'b1);

  assign wr_ptr_nxt = PTR_W'(wr_ptr_r + nwr);
  assign rd_ptr_nxt = PTR_W'(rd_ptr_r + pop);
  assign cnt_nxt    = CNT_W'(cnt_r + CNT_W'(nwr) - CNT_W'(pop));

  // accept an item only when both of its possible results fit
  assign room      = (cnt_r <= CNT_W'(FIFO_DEPTH - 2));
  assign out_valid = (cnt_r != '0);
  assign out_data  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr.vld0)
      mem[wr_ptr_r] <= wr.item0;
    if (wr.vld1)
      mem[wr_ptr_p1] <= wr.item1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/token_scanner_dfa_unit.sv =====
// Token scanner top level: input register, scanner core, result queue.
// Depends on tsd_pkg, tsd_core, tsd_res_fifo and assert_macros.svh.
//
//   channel | ports                          | payload
//   --------+--------------------------------+------------------------------------
//   input   | in_valid, in_ready, in_data    | char_code, end_of_input
//   result  | out_valid, out_ready, out_data | token_kind, lexeme_length, last
//
// An item is registered at acceptance and scanned once the result queue has room; its
// results are written into the queue. One item is accepted per cycle while the queue has
// room; each result leaves on its own through the single output port, so an item giving
// two results holds that port for two transfers. The four-entry result queue sets how far
// input runs ahead of a stalled output. Reset is synchronous and clears state and queue.
`default_nettype none
`include "assert_macros.svh"

module token_scanner_dfa_unit
  import tsd_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  in_item_t in_item_r;
  logic     in_vld_r, in_vld_nxt;
  logic     room;
  logic     proc_fire;
  res_wr_t  res_wr;

  assign proc_fire  = in_vld_r && room;
  assign in_ready   = !in_vld_r || proc_fire;
  assign in_vld_nxt = in_ready ? in_valid : in_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n)
      in_vld_r <= 1'b0;
    else
      in_vld_r <= in_vld_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready)
      in_item_r <= in_data;
  end

  tsd_core #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .fire (proc_fire),
    .item (in_item_r),
    .wr   (res_wr)
  );

  tsd_res_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (res_wr),
    .room     (room),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  `ASSERT_CLK(a_eoi_gives_result, clk, rst_n, proc_fire && in_item_r.end_of_input |-> res_wr.vld0, "end of input produced no result")
  `ASSERT_CLK(a_two_results_order, clk, rst_n, res_wr.vld1 |-> res_wr.vld0 && !res_wr.item0.last && res_wr.item1.last, "bad order or last flag on a result pair")
  `ASSERT_CLK(a_one_result_last, clk, rst_n, res_wr.vld0 && !res_wr.vld1 |-> res_wr.item0.last, "single result lacks last flag")
  `ASSERT_NORST(a_reset_empties_queue, clk, !rst_n |=> !out_valid, "result queue not empty after reset")

endmodule

`default_nettype wire
